// ===== hdl/tccs_pkg.sv =====
// tccs_pkg: shared constants, types and helpers of the text console engine
// depends on: nothing
package tccs_pkg;

  // screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);

  // transaction field widths
  localparam int FUNC_W = 2;
  localparam int CH_W   = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = 11;
  localparam int LOC_W  = 11;
  localparam int DATA_W = 16;

  // command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // character codes and cell values
  localparam logic [CH_W-1:0]   CH_TAB     = 8'd9;
  localparam logic [CH_W-1:0]   CH_NEWLINE = 8'd10;
  localparam logic [CH_W-1:0]   BLANK_CHAR = 8'h20;
  localparam logic [DATA_W-1:0] RESET_CELL = 16'h0720;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_NEWLINE,
    OP_TAB,
    OP_DRAW,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic [ATTR_W-1:0] attr;
    logic [CELL_W-1:0] addr;
    logic              addr_ok;
  } cmd_t;

  // linear cell index of a cursor position
  function automatic logic [CELL_W-1:0] cell_index(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
    logic [CNT_W-1:0] full;
    full = CNT_W'(row) * CNT_W'(COLS) + CNT_W'(col);
    return full[CELL_W-1:0];
  endfunction

  // cursor location as reported in the result
  function automatic logic [LOC_W-1:0] cell_loc(logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col);
    logic [CNT_W-1:0] full;
    full = CNT_W'(row) * CNT_W'(COLS) + CNT_W'(col);
    return LOC_W'(full);
  endfunction

  function automatic logic [DATA_W-1:0] blank_cell(logic [ATTR_W-1:0] attr);
    return {attr, BLANK_CHAR};
  endfunction

endpackage

// ===== hdl/tccs_ifs.sv =====
// tccs_in_if / tccs_out_if: valid-ready channels of the text console engine
// depends on: tccs_pkg
interface tccs_in_if;
  logic                          valid;
  logic                          ready;
  logic [tccs_pkg::FUNC_W-1:0]   func;
  logic [tccs_pkg::CH_W-1:0]     ch;
  logic [tccs_pkg::ATTR_W-1:0]   attr;
  logic [tccs_pkg::ADDR_W-1:0]   cell_addr;

  modport source (output valid, func, ch, attr, cell_addr, input ready);
  modport sink   (input valid, func, ch, attr, cell_addr, output ready);
endinterface

interface tccs_out_if;
  logic                          valid;
  logic                          ready;
  logic [tccs_pkg::LOC_W-1:0]    cursor_loc;
  logic [tccs_pkg::DATA_W-1:0]   cell_data;

  modport source (output valid, cursor_loc, cell_data, input ready);
  modport sink   (input valid, cursor_loc, cell_data, output ready);
endinterface

// ===== hdl/tccs_front.sv =====
// tccs_front: accepts request transactions, decodes them into commands and
// queues them for the back end; depends on tccs_pkg and tccs_in_if
module tccs_front (
  input  logic            clk,
  input  logic            rst,
  tccs_in_if.sink         cmd_in,
  input  logic            accept_en,
  input  logic            pop,
  output logic            head_valid,
  output tccs_pkg::cmd_t  head
);

  tccs_pkg::cmd_t              decoded;
  tccs_pkg::cmd_t              queue [tccs_pkg::QDEPTH];
  logic [tccs_pkg::QPTR_W-1:0] wptr;
  logic [tccs_pkg::QPTR_W-1:0] rptr;
  logic [tccs_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        do_pop;

  // decode the request into a command
  always_comb begin
    decoded.ch      = cmd_in.ch;
    decoded.attr    = cmd_in.attr;
    decoded.addr    = tccs_pkg::CELL_W'(cmd_in.cell_addr);
    decoded.addr_ok = 32'(cmd_in.cell_addr) < 32'(tccs_pkg::CELLS);
    case (cmd_in.func)
      tccs_pkg::FUNC_PUT: begin
        if (cmd_in.ch == tccs_pkg::CH_NEWLINE) begin
          decoded.op = tccs_pkg::OP_NEWLINE;
        end else if (cmd_in.ch == tccs_pkg::CH_TAB) begin
          decoded.op = tccs_pkg::OP_TAB;
        end else begin
          decoded.op = tccs_pkg::OP_DRAW;
        end
      end
      tccs_pkg::FUNC_CLEAR: decoded.op = tccs_pkg::OP_CLEAR;
      tccs_pkg::FUNC_READ:  decoded.op = tccs_pkg::OP_READ;
      default:              decoded.op = tccs_pkg::OP_NOP;
    endcase
  end

  // queue handshake
  assign cmd_in.ready = accept_en && (count != tccs_pkg::QCNT_W'(tccs_pkg::QDEPTH));
  assign push         = cmd_in.valid && cmd_in.ready;
  assign head_valid   = (count != '0);
  assign do_pop       = pop && head_valid;
  assign head         = queue[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= decoded;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == tccs_pkg::QPTR_W'(tccs_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == tccs_pkg::QPTR_W'(tccs_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == tccs_pkg::QCNT_W'(tccs_pkg::QDEPTH) |-> !push)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == '0 |=> count == '0 || count == tccs_pkg::QCNT_W'(1))
    else $error("command queue count jumped from empty");

  a_closed_in_init: assert property (@(posedge clk) disable iff (rst)
    !accept_en |-> !push)
    else $error("transaction taken while screen is being initialized");

endmodule

// ===== hdl/tccs_back.sv =====
// tccs_back: executes console commands on the screen memory and the cursor,
// sweeps for scroll and clear, holds the result register
// depends on: tccs_pkg and tccs_out_if
module tccs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  tccs_pkg::cmd_t  head,
  output logic            pop,
  output logic            accept_en,
  tccs_out_if.source      res_out
);

  tccs_pkg::state_t               state, state_next;
  tccs_pkg::cmd_t                 cur;
  logic [tccs_pkg::ROW_W-1:0]     row, row_next;
  logic [tccs_pkg::COL_W-1:0]     col, col_next;
  logic [tccs_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic [tccs_pkg::DATA_W-1:0]    res_data;
  logic                           out_valid;
  logic [tccs_pkg::LOC_W-1:0]     out_loc;
  logic [tccs_pkg::DATA_W-1:0]    out_data;

  logic [tccs_pkg::DATA_W-1:0]    screen_mem [tccs_pkg::CELLS];
  logic                           we;
  logic [tccs_pkg::CELL_W-1:0]    waddr;
  logic [tccs_pkg::DATA_W-1:0]    wdata;
  logic [tccs_pkg::CELL_W-1:0]    raddr;
  logic [tccs_pkg::DATA_W-1:0]    rd_data;

  logic [tccs_pkg::ROW_W:0]       nl_row;
  logic                           nl_scroll;
  logic [tccs_pkg::COL_W:0]       tab_col;
  logic                           tab_wrap;
  logic                           draw_wrap;
  logic [tccs_pkg::CNT_W-1:0]     copy_src;
  logic [tccs_pkg::CNT_W-1:0]     copy_dst;
  logic                           do_nl;
  logic                           finish;
  logic [tccs_pkg::DATA_W-1:0]    fin_data;
  logic                           out_free;
  logic                           load;

  // cursor arithmetic
  assign nl_row    = {1'b0, row} + 1'b1;
  assign nl_scroll = nl_row >= (tccs_pkg::ROW_W + 1)'(tccs_pkg::ROWS);
  assign tab_col   = ({1'b0, col} + (tccs_pkg::COL_W + 1)'(4))
                     & {{(tccs_pkg::COL_W - 1){1'b1}}, 2'b00};
  assign tab_wrap  = tab_col >= (tccs_pkg::COL_W + 1)'(tccs_pkg::COLS - 1);
  assign draw_wrap = col >= tccs_pkg::COL_W'(tccs_pkg::COLS - 1);

  // scroll copy addresses: read one row below, write what came back last cycle
  assign copy_src = cnt + tccs_pkg::CNT_W'(tccs_pkg::COLS);
  assign copy_dst = cnt - 1'b1;

  assign out_free  = !out_valid || res_out.ready;
  assign accept_en = (state != tccs_pkg::ST_INIT);
  assign pop       = (state == tccs_pkg::ST_IDLE) && head_valid;

  // sequencer
  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    cnt_next   = cnt;
    we         = 1'b0;
    waddr      = cnt[tccs_pkg::CELL_W-1:0];
    wdata      = tccs_pkg::RESET_CELL;
    raddr      = copy_src[tccs_pkg::CELL_W-1:0];
    do_nl      = 1'b0;
    finish     = 1'b0;
    fin_data   = '0;
    load       = 1'b0;

    case (state)
      tccs_pkg::ST_INIT: begin
        we = 1'b1;
        if (cnt == tccs_pkg::CNT_W'(tccs_pkg::CELLS - 1)) begin
          state_next = tccs_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_IDLE: begin
        raddr = head.addr;
        if (head_valid) begin
          case (head.op)
            tccs_pkg::OP_NEWLINE: do_nl = 1'b1;
            tccs_pkg::OP_TAB: begin
              if (tab_wrap) begin
                do_nl = 1'b1;
              end else begin
                col_next = tab_col[tccs_pkg::COL_W-1:0];
                finish   = 1'b1;
              end
            end
            tccs_pkg::OP_DRAW: begin
              if (draw_wrap) begin
                do_nl = 1'b1;
              end else begin
                we       = 1'b1;
                waddr    = tccs_pkg::cell_index(row, col);
                wdata    = {head.attr, head.ch};
                col_next = col + 1'b1;
                finish   = 1'b1;
              end
            end
            tccs_pkg::OP_CLEAR: begin
              cnt_next   = '0;
              row_next   = tccs_pkg::ROW_W'(1);
              col_next   = tccs_pkg::COL_W'(1);
              state_next = tccs_pkg::ST_CLEAR;
            end
            tccs_pkg::OP_READ: state_next = tccs_pkg::ST_READ;
            default:           finish = 1'b1;
          endcase

          // line feed, with scroll when it runs off the bottom
          if (do_nl) begin
            col_next = tccs_pkg::COL_W'(1);
            if (nl_scroll) begin
              row_next   = tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1);
              cnt_next   = '0;
              state_next = tccs_pkg::ST_COPY;
            end else begin
              row_next = nl_row[tccs_pkg::ROW_W-1:0];
              if (head.op == tccs_pkg::OP_DRAW) begin
                state_next = tccs_pkg::ST_WRITE;
              end else begin
                finish = 1'b1;
              end
            end
          end
        end
      end

      tccs_pkg::ST_COPY: begin
        we    = (cnt != '0);
        waddr = copy_dst[tccs_pkg::CELL_W-1:0];
        wdata = rd_data;
        if (cnt == tccs_pkg::CNT_W'(tccs_pkg::CELLS - tccs_pkg::COLS)) begin
          cnt_next   = tccs_pkg::CNT_W'((tccs_pkg::ROWS - 1) * tccs_pkg::COLS);
          state_next = tccs_pkg::ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_FILL: begin
        we    = 1'b1;
        wdata = tccs_pkg::blank_cell(cur.attr);
        if (cnt == tccs_pkg::CNT_W'(tccs_pkg::CELLS - 1)) begin
          if (cur.op == tccs_pkg::OP_DRAW) begin
            state_next = tccs_pkg::ST_WRITE;
          end else begin
            finish = 1'b1;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_CLEAR: begin
        we    = 1'b1;
        wdata = tccs_pkg::blank_cell(cur.attr);
        if (cnt == tccs_pkg::CNT_W'(tccs_pkg::CELLS - 1)) begin
          finish = 1'b1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_WRITE: begin
        we       = 1'b1;
        waddr    = tccs_pkg::cell_index(row, col);
        wdata    = {cur.attr, cur.ch};
        col_next = col + 1'b1;
        finish   = 1'b1;
      end

      tccs_pkg::ST_READ: begin
        fin_data = cur.addr_ok ? rd_data : '0;
        finish   = 1'b1;
      end

      tccs_pkg::ST_DONE: begin
        fin_data = res_data;
        finish   = 1'b1;
      end

      default: state_next = tccs_pkg::ST_IDLE;
    endcase

    // hand the result to the output register or park it
    if (finish) begin
      if (out_free) begin
        load       = 1'b1;
        state_next = tccs_pkg::ST_IDLE;
      end else begin
        state_next = tccs_pkg::ST_DONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tccs_pkg::ST_INIT;
      row       <= tccs_pkg::ROW_W'(1);
      col       <= tccs_pkg::COL_W'(1);
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      cnt   <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (finish) begin
      res_data <= fin_data;
    end
    if (load) begin
      out_loc  <= tccs_pkg::cell_loc(row_next, col_next);
      out_data <= fin_data;
    end
  end

  // screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      screen_mem[waddr] <= wdata;
    end
    rd_data <= screen_mem[raddr];
  end

  assign res_out.valid      = out_valid;
  assign res_out.cursor_loc = out_loc;
  assign res_out.cell_data  = out_data;

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col != '0 && col <= tccs_pkg::COL_W'(tccs_pkg::COLS - 1))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row < tccs_pkg::ROW_W'(tccs_pkg::ROWS))
    else $error("cursor row out of range");

  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    we && state == tccs_pkg::ST_IDLE |-> head_valid && head.op == tccs_pkg::OP_DRAW)
    else $error("screen write in idle without a drawn character");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    state == tccs_pkg::ST_COPY |-> row == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1))
    else $error("scroll running with cursor off the bottom row");

endmodule

// ===== hdl/text_console_cursor_scroll.sv =====
// text_console_cursor_scroll: top level of the text console engine
// depends on: tccs_pkg, tccs_in_if, tccs_out_if, tccs_front, tccs_back
//
// Text console of COLS x ROWS cells (80 x 25) with a cursor. Each request
// transaction yields one result transaction carrying the cursor location and,
// for a read, the cell. Requests are decoded and held in a two-entry queue;
// the back end runs them one at a time against a single-port-write,
// registered-read screen memory. A drawn character, tab or newline without
// scroll finishes from idle (a wrapping draw via the write state), a read via
// the read state. A scroll sweeps the memory: a copy pass moves every row up
// by one, then a fill pass blanks the bottom row; clear sweeps all CELLS cells.
// After reset a clearing pass writes the blank light-gray cell everywhere, and
// no request is accepted until it ends. The result register lets the back end
// finish the next command while a result still waits on the output.
module text_console_cursor_scroll (
  input  logic        clk,
  input  logic        rst,
  tccs_in_if.sink     cmd_in,
  tccs_out_if.source  res_out
);

  logic           accept_en;
  logic           pop;
  logic           head_valid;
  tccs_pkg::cmd_t head;

  // decode and queue
  tccs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (cmd_in),
    .accept_en  (accept_en),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // execute on the screen memory
  tccs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .accept_en  (accept_en),
    .res_out    (res_out)
  );

endmodule

// ===== tb/sv/text_console_cursor_scroll_checker.sv =====
`timescale 1ns / 1ps
// text_console_cursor_scroll_checker: scoreboard of the text console engine
// keeps its own screen and cursor, predicts every result and compares it
// depends on: tccs_pkg, tccs_in_if, tccs_out_if
module text_console_cursor_scroll_checker
  import tccs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tccs_in_if   cmd,
  tccs_out_if  res,
  output int   results_due,
  output int   mismatch_count
);

  typedef struct packed {
    logic [LOC_W-1:0]  loc;
    logic [DATA_W-1:0] data;
  } console_result_t;

  logic [DATA_W-1:0] shadow_screen [CELLS];
  int unsigned       shadow_col;
  int unsigned       shadow_row;
  console_result_t   results_q [$];
  int                errs = 0;

  // screen and cursor right after reset
  function automatic void reset_console();
    int i;
    for (i = 0; i < CELLS; i++) shadow_screen[i] = RESET_CELL;
    shadow_col = 1;
    shadow_row = 1;
  endfunction

  // shift every row up by one, bottom row gets blanks in the given colour
  function automatic void scroll_screen(logic [ATTR_W-1:0] attr);
    int i;
    for (i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
    for (i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {attr, BLANK_CHAR};
  endfunction

  // carriage return plus line feed, scrolling below the last row
  function automatic void line_feed(logic [ATTR_W-1:0] attr);
    shadow_row++;
    shadow_col = 1;
    if (shadow_row >= ROWS) begin
      scroll_screen(attr);
      shadow_row = ROWS - 1;
    end
  endfunction

  // apply one request and return the result it produces
  function automatic console_result_t predict_console(logic [FUNC_W-1:0] func,
                                                      logic [CH_W-1:0]   ch,
                                                      logic [ATTR_W-1:0] attr,
                                                      logic [ADDR_W-1:0] addr);
    console_result_t r;
    int unsigned     idx;
    int              i;
    r.data = '0;
    case (func)
      FUNC_PUT: begin
        if (ch == CH_NEWLINE) begin
          line_feed(attr);
        end else if (ch == CH_TAB) begin
          shadow_col = (shadow_col + 4) & ~32'd3;
          if (shadow_col >= COLS - 1) line_feed(attr);
        end else begin
          // wrap first when the line is full, then draw
          if (shadow_col >= COLS - 1) line_feed(attr);
          idx = shadow_row * COLS + shadow_col;
          if (idx < CELLS) shadow_screen[idx] = {attr, ch};
          shadow_col++;
        end
      end
      FUNC_CLEAR: begin
        for (i = 0; i < CELLS; i++) shadow_screen[i] = {attr, BLANK_CHAR};
        shadow_col = 1;
        shadow_row = 1;
      end
      FUNC_READ: begin
        if (addr < CELLS) r.data = shadow_screen[addr];
      end
      default: ;
    endcase
    r.loc = LOC_W'(shadow_row * COLS + shadow_col);
    return r;
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      reset_console();
      results_q.delete();
    end else begin
      // result transaction against the oldest prediction
      if (res.valid && res.ready) begin
        if (results_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none actual loc %0d data %h",
                   $time, res.cursor_loc, res.cell_data);
        end else begin
          want = results_q.pop_front();
          if (res.cursor_loc !== want.loc) begin
            errs++;
            $display("%0t: cursor_loc mismatch, expected %0d actual %0d",
                     $time, want.loc, res.cursor_loc);
          end
          if (res.cell_data !== want.data) begin
            errs++;
            $display("%0t: cell_data mismatch, expected %h actual %h",
                     $time, want.data, res.cell_data);
          end
        end
      end
      // request transaction updates the shadow console
      if (cmd.valid && cmd.ready)
        results_q.push_back(predict_console(cmd.func, cmd.ch, cmd.attr, cmd.cell_addr));
    end
    results_due    <= results_q.size();
    mismatch_count <= errs;
  end

endmodule

// ===== tb/sv/text_console_cursor_scroll_tb.sv =====
`timescale 1ns / 1ps
// text_console_cursor_scroll_tb: stimulus, back-pressure and verdict for the console
// depends on: tccs_pkg, tccs_in_if, tccs_out_if, text_console_cursor_scroll,
//   text_console_cursor_scroll_checker
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;  // unused code, leaves state alone
  localparam int ADDR_MAX     = (1 << ADDR_W) - 1;
  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT  = 30000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic             clk;
  logic             rst;
  int               results_due;
  int               mismatch_count;
  int               sent = 0;
  int               taken = 0;
  bit               sender_quiet = 1'b0;
  logic [LOC_W-1:0] last_loc = LOC_W'(COLS + 1);

  tccs_in_if  cmd_in();
  tccs_out_if res_out();

  text_console_cursor_scroll dut (
    .clk,
    .rst,
    .cmd_in  (cmd_in),
    .res_out (res_out)
  );

  text_console_cursor_scroll_checker scoreboard (
    .clk,
    .rst,
    .cmd            (cmd_in),
    .res            (res_out),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one request transaction, preceded by a random gap unless in a quiet burst
  task automatic send_request(logic [FUNC_W-1:0] func, logic [CH_W-1:0] ch,
                              logic [ATTR_W-1:0] attr, logic [ADDR_W-1:0] addr);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_in.valid     <= 1'b1;
    cmd_in.func      <= func;
    cmd_in.ch        <= ch;
    cmd_in.attr      <= attr;
    cmd_in.cell_addr <= addr;
    @(posedge clk);
    while (!cmd_in.ready) @(posedge clk);
    sent++;
  endtask

  // a cell at or just behind the last reported cursor
  function automatic logic [ADDR_W-1:0] near_cursor();
    int unsigned back;
    back = $urandom_range(0, 3);
    return (last_loc > back) ? ADDR_W'(last_loc - back) : ADDR_W'(last_loc);
  endfunction

  // stimulus
  initial begin
    int                kind;
    int                len;
    int                i;
    int                base;
    logic [ATTR_W-1:0] line_attr;
    logic [CH_W-1:0]   glyph;
    rst              <= 1'b1;
    cmd_in.valid     <= 1'b0;
    cmd_in.func      <= FUNC_PUT;
    cmd_in.ch        <= '0;
    cmd_in.attr      <= '0;
    cmd_in.cell_addr <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset contents, edges of the address range
    send_request(FUNC_READ, '0, '0, '0);
    send_request(FUNC_READ, '0, '0, ADDR_W'(CELLS - 1));
    send_request(FUNC_READ, '0, '0, ADDR_W'(CELLS));
    send_request(FUNC_READ, '1, '1, '1);
    // draws with extreme bytes and colours, a tab between
    send_request(FUNC_PUT, 8'h41, 8'h1F, '0);
    send_request(FUNC_PUT, 8'h00, 8'h00, '0);
    send_request(FUNC_PUT, 8'hFF, 8'hFF, '1);
    send_request(FUNC_PUT, CH_TAB, 8'h0F, '0);
    send_request(FUNC_PUT, 8'h7E, 8'hF0, '0);
    send_request(FUNC_READ, '0, '0, ADDR_W'(COLS + 1));
    send_request(FUNC_READ, '0, '0, ADDR_W'(COLS + 3));
    send_request(FUNC_READ, '0, '0, ADDR_W'(COLS + 8));
    send_request(FUNC_PUT, CH_NEWLINE, 8'h3C, '0);
    // unused function code with every bit set
    send_request(FUNC_NONE, '1, '1, '1);
    send_request(FUNC_READ, '0, '0, ADDR_W'(2 * COLS + 1));
    // clear writes row zero too
    send_request(FUNC_CLEAR, 8'h55, 8'hA5, '0);
    send_request(FUNC_READ, '0, '0, '0);
    send_request(FUNC_READ, '0, '0, ADDR_W'(CELLS - 1));
    send_request(FUNC_PUT, 8'h78, 8'h5A, '0);
    send_request(FUNC_READ, '0, '0, ADDR_W'(COLS + 1));

    // random bursts, mostly text lines
    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      kind         = $urandom_range(0, 99);
      sender_quiet = ($urandom_range(0, 3) == 0);
      if (kind < 50) begin
        // a line of text, usually closed by a newline, then a look at it
        line_attr = ATTR_W'($urandom_range(0, 255));
        len       = $urandom_range(1, 100);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) glyph = CH_W'($urandom_range(0, 255));
          else glyph = CH_W'($urandom_range(BLANK_CHAR, 8'h7E));
          send_request(FUNC_PUT, glyph, line_attr, ADDR_W'($urandom_range(0, ADDR_MAX)));
        end
        if ($urandom_range(0, 9) < 7) send_request(FUNC_PUT, CH_NEWLINE, line_attr, '0);
        repeat ($urandom_range(0, 3)) send_request(FUNC_READ, '0, '0, near_cursor());
      end else if (kind < 60) begin
        // tabs toward the right edge, some text between
        line_attr = ATTR_W'($urandom_range(0, 255));
        len       = $urandom_range(1, 25);
        for (i = 0; i < len; i++) begin
          send_request(FUNC_PUT, CH_TAB, line_attr, '0);
          if ($urandom_range(0, 2) == 0)
            send_request(FUNC_PUT, CH_W'($urandom_range(BLANK_CHAR, 8'h7E)), line_attr, '0);
        end
      end else if (kind < 65) begin
        // run of newlines, scrolls at the bottom
        len = $urandom_range(1, 30);
        for (i = 0; i < len; i++)
          send_request(FUNC_PUT, CH_NEWLINE, ATTR_W'($urandom_range(0, 255)), '0);
      end else if (kind < 80) begin
        // reads near the cursor, anywhere, or off the screen
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0, 1: send_request(FUNC_READ, '0, '0, near_cursor());
            2: send_request(FUNC_READ, '0, '0, ADDR_W'($urandom_range(0, CELLS - 1)));
            default: send_request(FUNC_READ, '0, '0,
                                  ADDR_W'($urandom_range(CELLS, ADDR_MAX)));
          endcase
        end
      end else if (kind < 83) begin
        send_request(FUNC_CLEAR, CH_W'($urandom_range(0, 255)),
                     ATTR_W'($urandom_range(0, 255)), '0);
      end else begin
        // unconstrained transactions
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++)
          send_request(FUNC_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 255)),
                       ATTR_W'($urandom_range(0, 255)),
                       ADDR_W'($urandom_range(0, ADDR_MAX)));
      end
    end
    cmd_in.valid <= 1'b0;

    // drain, then verdict
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS text_console_cursor_scroll");
    end else begin
      $display("FAIL text_console_cursor_scroll");
    end
    $finish;
  end

  // result side: random stalls, quiet stretches, two long hold-offs
  initial begin
    int stall;
    res_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 150 || taken == 450) stall = HOLD_CYCLES;
      else if (taken % 128 < 32) stall = 0;
      else stall = $urandom_range(0, 19);
      if (stall > 0) begin
        res_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_out.ready <= 1'b1;
      @(posedge clk);
      while (!res_out.valid) @(posedge clk);
      last_loc = res_out.cursor_loc;
      taken++;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_in.valid && cmd_in.ready) || (res_out.valid && res_out.ready))
        idle = 0;
      else
        idle++;
    end
    $display("FAIL text_console_cursor_scroll");
    $finish;
  end

endmodule

// ===== text_console_cursor_scroll.f =====
hdl/tccs_pkg.sv
hdl/tccs_ifs.sv
hdl/tccs_front.sv
hdl/tccs_back.sv
hdl/text_console_cursor_scroll.sv
tb/sv/text_console_cursor_scroll_checker.sv
tb/sv/text_console_cursor_scroll_tb.sv
